/* hdl/iaif_pkg.sv */
`default_nettype none
package iaif_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned HIT_W    = 6;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
  localparam logic [OP_W-1:0] OP_RESIZE = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd4;

endpackage
`default_nettype wire

/* hdl/iaif_ram.sv */
`default_nettype none
module iaif_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

/* hdl/indexed_array_insert_remove_find.sv */
`default_nettype none
// read, write, clear, resize down and every rejected request answer without a walk (a
// successful read passes through the memory read state); the memory read port sets one
// element per cycle for the shift and find walks: insert and remove move each element behind
// the position, find scans up to the first match, and resize up zero-fills the new places;
// one request at a time
// rst_n (synchronous) empties the array; element storage is not cleared
module indexed_array_insert_remove_find #(
  parameter int unsigned CAPACITY = iaif_pkg::CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic        [iaif_pkg::OP_W-1:0]     in_operation,
  input  wire logic        [iaif_pkg::POS_W-1:0]    in_position,
  input  wire logic signed [iaif_pkg::WORD_W-1:0]   in_word_in,
  input  wire logic        [iaif_pkg::LEN_W-1:0]    in_target_length,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic             [iaif_pkg::STATUS_W-1:0] out_status,
  output logic signed      [iaif_pkg::WORD_W-1:0]   out_word_out,
  output logic             [iaif_pkg::HIT_W-1:0]    out_match_index,
  output logic             [iaif_pkg::LEN_W-1:0]    out_current_length
);
  import iaif_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [CW-1:0]       tlen_r, tlen_nxt;
  logic [AW-1:0]       src_r, src_nxt;
  logic                more_r, more_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       dst_r, dst_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [WORD_W-1:0]   res_word_r, res_word_nxt;
  logic [AW-1:0]       res_hit_r, res_hit_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [HIT_W-1:0]    out_hit_r;
  logic [LEN_W-1:0]    out_len_r;
  logic                out_load;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic [MW-1:0]       pos_ext, fill_ext, tlen_ext, cap_ext;
  logic                in_take;

  iaif_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign pos_ext  = MW'(in_position);
  assign fill_ext = MW'(fill_r);
  assign tlen_ext = MW'(in_target_length);
  assign cap_ext  = MW'(CAPACITY);

  assign out_load = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    word_nxt       = word_r;
    tlen_nxt       = tlen_r;
    src_nxt        = src_r;
    more_nxt       = more_r;
    pend_nxt       = pend_r;
    dst_nxt        = dst_r;
    res_status_nxt = res_status_r;
    res_word_nxt   = res_word_r;
    res_hit_nxt    = res_hit_r;
    ram_we         = 1'b0;
    ram_waddr      = src_r;
    ram_wdata      = word_r;
    ram_raddr      = src_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          op_nxt         = in_operation;
          pos_nxt        = AW'(in_position);
          word_nxt       = WORD_W'(in_word_in);
          res_status_nxt = ST_OK;
          res_word_nxt   = '0;
          res_hit_nxt    = '0;
          pend_nxt       = 1'b0;
          state_nxt      = S_RESP;
          case (in_operation)
            OP_READ: begin
              if (pos_ext < fill_ext) begin
                ram_raddr = AW'(in_position);
                state_nxt = S_READ;
              end else begin
                res_status_nxt = ST_BAD_INDEX;
              end
            end
            OP_WRITE: begin
              if (pos_ext < fill_ext) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(in_position);
                ram_wdata = WORD_W'(in_word_in);
              end else begin
                res_status_nxt = ST_BAD_INDEX;
              end
            end
            OP_INSERT: begin
              if (pos_ext > fill_ext) begin
                res_status_nxt = ST_BAD_INDEX;
              end else if (fill_ext == cap_ext) begin
                res_status_nxt = ST_FULL;
              end else begin
                // walk down from the last element, moving each one up a place
                src_nxt   = AW'(fill_r - CW'(1));
                more_nxt  = (pos_ext < fill_ext);
                state_nxt = S_SHIFT;
              end
            end
            OP_REMOVE: begin
              if (pos_ext < fill_ext) begin
                src_nxt   = AW'(in_position) + AW'(1);
                more_nxt  = ((pos_ext + MW'(1)) < fill_ext);
                state_nxt = S_SHIFT;
              end else begin
                res_status_nxt = ST_BAD_INDEX;
              end
            end
            OP_FIND: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                src_nxt   = '0;
                more_nxt  = 1'b1;
                state_nxt = S_FIND;
              end
            end
            OP_RESIZE: begin
              if (tlen_ext > cap_ext) begin
                res_status_nxt = ST_BAD_LENGTH;
              end else if (tlen_ext > fill_ext) begin
                src_nxt   = AW'(fill_r);
                tlen_nxt  = CW'(in_target_length);
                state_nxt = S_FILL;
              end else begin
                fill_nxt = CW'(in_target_length);
              end
            end
            OP_CLEAR: begin
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        res_word_nxt = ram_rdata;
        state_nxt    = S_RESP;
      end

      S_SHIFT: begin
        // one read issued and one write retired per cycle, never the same entry
        pend_nxt = more_r;
        if (more_r) begin
          ram_raddr = src_r;
          if (op_r == OP_INSERT) begin
            dst_nxt  = src_r + AW'(1);
            more_nxt = (src_r != pos_r);
            src_nxt  = src_r - AW'(1);
          end else begin
            dst_nxt  = src_r - AW'(1);
            more_nxt = ((CW'(src_r) + CW'(1)) < fill_r);
            src_nxt  = src_r + AW'(1);
          end
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = ram_rdata;
        end
        if (!more_r && !pend_r) begin
          if (op_r == OP_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r;
            ram_wdata = word_r;
            fill_nxt  = fill_r + CW'(1);
          end else begin
            fill_nxt = fill_r - CW'(1);
          end
          state_nxt = S_RESP;
        end
      end

      S_FIND: begin
        pend_nxt = more_r;
        if (more_r) begin
          ram_raddr = src_r;
          dst_nxt   = src_r;
          more_nxt  = ((CW'(src_r) + CW'(1)) < fill_r);
          src_nxt   = src_r + AW'(1);
        end
        if (pend_r && (ram_rdata == word_r)) begin
          res_hit_nxt = dst_r;
          state_nxt   = S_RESP;
        end else if (!more_r) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = src_r;
        ram_wdata = '0;
        src_nxt   = src_r + AW'(1);
        if ((CW'(src_r) + CW'(1)) == tlen_r) begin
          fill_nxt  = tlen_r;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      more_r      <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      more_r      <= more_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    word_r       <= word_nxt;
    tlen_r       <= tlen_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    res_status_r <= res_status_nxt;
    res_word_r   <= res_word_nxt;
    res_hit_r    <= res_hit_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_word_r   <= res_word_r;
      out_hit_r    <= HIT_W'(res_hit_r);
      out_len_r    <= LEN_W'(fill_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_word_out       = out_word_r;
  assign out_match_index    = out_hit_r;
  assign out_current_length = out_len_r;

endmodule
`default_nettype wire

/* bench/tb_top.sv */
module tb_top;
  import iaif_pkg::*;

  localparam int unsigned DEPTH = CAPACITY_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  // covers the longest walk, a full shift or search, plus its request and response states
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic signed [WORD_W-1:0]   word;
    logic        [HIT_W-1:0]    hit;
    logic        [LEN_W-1:0]    len;
  } array_reply_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic        [OP_W-1:0]     in_operation = OP_READ;
  logic        [POS_W-1:0]    in_position = '0;
  logic signed [WORD_W-1:0]   in_word_in = '0;
  logic        [LEN_W-1:0]    in_target_length = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic        [STATUS_W-1:0] out_status;
  logic signed [WORD_W-1:0]   out_word_out;
  logic        [HIT_W-1:0]    out_match_index;
  logic        [LEN_W-1:0]    out_current_length;

  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned              shadow_len = 0;
  array_reply_t             replies_due [$];
  int unsigned              err_count = 0;
  bit                       gapless = 1'b0;
  int unsigned              hold_cycles = 0;

  always #5 clk = ~clk;

  indexed_array_insert_remove_find dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_word_in         (in_word_in),
    .in_target_length   (in_target_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_word_out       (out_word_out),
    .out_match_index    (out_match_index),
    .out_current_length (out_current_length)
  );

  // updates the shadow array and returns the reply the block must give
  function automatic array_reply_t apply_array_request(
    input logic        [OP_W-1:0]   op,
    input logic        [POS_W-1:0]  pos,
    input logic signed [WORD_W-1:0] word,
    input logic        [LEN_W-1:0]  tlen
  );
    array_reply_t r;
    int unsigned  i;
    bit           found;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    case (op)
      OP_READ: begin
        if (pos < shadow_len) r.word = shadow_words[pos];
        else r.status = ST_BAD_INDEX;
      end
      OP_WRITE: begin
        if (pos < shadow_len) shadow_words[pos] = word;
        else r.status = ST_BAD_INDEX;
      end
      OP_INSERT: begin
        if (pos > shadow_len) begin
          r.status = ST_BAD_INDEX;
        end else if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = word;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        if (pos < shadow_len) begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
      OP_FIND: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < shadow_len && !found; i++) begin
          if (shadow_words[i] == word) begin
            found = 1'b1;
            r.status = ST_OK;
            r.hit = HIT_W'(i);
          end
        end
      end
      OP_RESIZE: begin
        if (tlen > DEPTH) begin
          r.status = ST_BAD_LENGTH;
        end else begin
          for (i = shadow_len; i < tlen; i++) shadow_words[i] = '0;
          shadow_len = 32'(tlen);
        end
      end
      OP_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.len = LEN_W'(shadow_len);
    return r;
  endfunction

  task automatic send_request(
    input logic        [OP_W-1:0]   op,
    input logic        [POS_W-1:0]  pos,
    input logic signed [WORD_W-1:0] word,
    input logic        [LEN_W-1:0]  tlen
  );
    @(negedge clk);
    while (!gapless && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_position      <= pos;
    in_word_in       <= word;
    in_target_length <= tlen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replies_due.push_back(apply_array_request(op, pos, word, tlen));
  endtask

  // drop valid, then wait for every outstanding reply and the walk latency
  task automatic drain_replies;
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_array;
    send_request(OP_FIND, 7'd0, 32'sd0, 7'd0);
    send_request(OP_READ, 7'd0, 32'sd0, 7'd0);
    send_request(OP_REMOVE, 7'd0, 32'sd0, 7'd0);
    send_request(OP_WRITE, 7'd0, 32'sd5, 7'd0);
    send_request(OP_INSERT, 7'd1, 32'sd5, 7'd0);
    send_request(OP_UNUSED, 7'd127, -32'sd1, 7'd127);
  endtask

  task automatic test_small_edits;
    send_request(OP_INSERT, 7'd0, 32'sh8000_0000, 7'd0);
    send_request(OP_INSERT, 7'd0, 32'sh7fff_ffff, 7'd0);
    send_request(OP_INSERT, 7'd2, -32'sd1, 7'd0);
    send_request(OP_READ, 7'd0, 32'sd0, 7'd0);
    send_request(OP_READ, 7'd1, 32'sd0, 7'd0);
    send_request(OP_READ, 7'd2, 32'sd0, 7'd0);
    send_request(OP_FIND, 7'd0, -32'sd1, 7'd0);
    send_request(OP_FIND, 7'd0, 32'sd12345, 7'd0);
    send_request(OP_WRITE, 7'd1, 32'sd0, 7'd0);
    send_request(OP_REMOVE, 7'd1, 32'sd0, 7'd0);
  endtask

  task automatic test_length_limits;
    send_request(OP_RESIZE, 7'd0, 32'sd0, 7'd65);
    send_request(OP_RESIZE, 7'd0, 32'sd0, 7'd127);
    send_request(OP_RESIZE, 7'd0, 32'sd0, 7'd2);
    send_request(OP_RESIZE, 7'd0, 32'sd0, 7'd64);
    send_request(OP_INSERT, 7'd64, 32'sd9, 7'd0);
    send_request(OP_INSERT, 7'd65, 32'sd9, 7'd0);
    send_request(OP_READ, 7'd63, 32'sd0, 7'd0);
    send_request(OP_WRITE, 7'd63, 32'sh7fff_ffff, 7'd0);
    send_request(OP_REMOVE, 7'd63, 32'sd0, 7'd0);
    send_request(OP_RESIZE, 7'd0, 32'sd0, 7'd0);
    send_request(OP_CLEAR, 7'd0, 32'sd0, 7'd0);
    drain_replies();
  endtask

  // mostly in-range requests with finds biased toward stored values
  task automatic test_random_traffic(input int unsigned count);
    int unsigned              done;
    int unsigned              pick;
    logic        [OP_W-1:0]   op;
    logic        [POS_W-1:0]  pos;
    logic signed [WORD_W-1:0] word;
    logic        [LEN_W-1:0]  tlen;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) op = OP_READ;
      else if (pick < 26) op = OP_WRITE;
      else if (pick < 46) op = OP_INSERT;
      else if (pick < 60) op = OP_REMOVE;
      else if (pick < 74) op = OP_FIND;
      else if (pick < 84) op = OP_RESIZE;
      else if (pick < 87) op = OP_CLEAR;
      else if (pick < 90) op = OP_UNUSED;
      else op = OP_INSERT;

      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 127));
      else if (op == OP_INSERT) pos = POS_W'($urandom_range(0, shadow_len));
      else if (shadow_len == 0) pos = '0;
      else pos = POS_W'($urandom_range(0, shadow_len - 1));

      pick = $urandom_range(0, 9);
      if (pick < 4 || shadow_len == 0) word = $urandom;
      else if (pick < 7) word = $signed($urandom_range(0, 7)) - 4;
      else word = shadow_words[$urandom_range(0, shadow_len - 1)];

      pick = $urandom_range(0, 9);
      if (pick == 0) tlen = LEN_W'($urandom_range(0, 127));
      else if (pick == 1) tlen = LEN_W'($urandom_range(62, 66));
      else tlen = LEN_W'($urandom_range(0, 40));

      send_request(op, pos, word, tlen);
      if (op != OP_UNUSED) done++;
    end
  endtask

  task automatic test_gapless_burst;
    gapless = 1'b1;
    test_random_traffic(150);
    gapless = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_output_backpressure;
    hold_cycles = 300;
    test_random_traffic(20);
    drain_replies();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= !gapless && ($urandom_range(0, 99) < 16);
    end
  end

  task automatic check_field(input string fname, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    array_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        err_count++;
        $display("%0t: transaction with nothing expected, expected none, actual status %0d",
                 $time, out_status);
      end else begin
        want = replies_due.pop_front();
        check_field("status", want.status, out_status);
        check_field("word_out", want.word, out_word_out);
        check_field("match_index", want.hit, out_match_index);
        check_field("current_length", want.len, out_current_length);
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_array();
    test_small_edits();
    test_length_limits();
    test_random_traffic(300);
    test_gapless_burst();
    test_output_backpressure();
    test_random_traffic(430);
    drain_replies();
    if (err_count == 0 && replies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
